// ===== src/brsm_pkg.sv =====
// Package for the radix-2 Booth signed multiplier core.
// Holds the operand width, the per-stage state type and the Booth step function.
// No dependencies.
package brsm_pkg;

  // Operand width in bits. The range 2..32 is supported.
  localparam int unsigned Width     = 8;
  localparam int unsigned AccWidth  = Width + 1;
  localparam int unsigned ProdWidth = 2 * Width;

  // Booth recoding of the bit pair {Q0, Q-1}
  localparam logic [1:0] BoothSub = 2'b10;
  localparam logic [1:0] BoothAdd = 2'b01;

  typedef logic signed [Width-1:0]     operand_t;
  typedef logic signed [ProdWidth-1:0] product_t;

  // Working state carried down the pipeline
  typedef struct packed {
    logic [AccWidth-1:0] acc;    // accumulator A, one bit wider than an operand
    logic [Width-1:0]    q;      // multiplier Q, shifted right one place per step
    logic                q_prev; // Q-1
    logic [AccWidth-1:0] m;      // sign-extended multiplicand
  } brsm_state_t;

  // One Booth step: add or subtract M, then shift A:Q:Q-1 right arithmetically
  function automatic brsm_state_t brsm_step(brsm_state_t s);
    brsm_state_t         r;
    logic [AccWidth-1:0] acc;
    acc = s.acc;
    case ({s.q[0], s.q_prev})
      BoothSub: acc = s.acc - s.m;
      BoothAdd: acc = s.acc + s.m;
      default:  acc = s.acc;
    endcase
    r.m      = s.m;
    r.q_prev = s.q[0];
    r.q      = {acc[0], s.q[Width-1:1]};
    r.acc    = {acc[AccWidth-1], acc[AccWidth-1:1]};
    return r;
  endfunction

endpackage

// ===== src/brsm_in_if.sv =====
// Operand channel of the Booth multiplier: valid/ready plus both operands.
// Depends on brsm_pkg.
interface brsm_in_if;
  import brsm_pkg::*;

  logic     valid;
  logic     ready;
  operand_t multiplicand;
  operand_t multiplier;

  modport source (output valid, output multiplicand, output multiplier, input ready);
  modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

// ===== src/brsm_out_if.sv =====
// Product channel of the Booth multiplier: valid/ready plus the product.
// Depends on brsm_pkg.
interface brsm_out_if;
  import brsm_pkg::*;

  logic     valid;
  logic     ready;
  product_t product;

  modport source (output valid, output product, input ready);
  modport sink   (input valid, input product, output ready);
endinterface

// ===== src/brsm_stage.sv =====
// One pipeline stage of the Booth multiplier: a single Booth step and its register.
// Depends on brsm_pkg.
module brsm_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  brsm_pkg::brsm_state_t state_i,
  output logic                  ready_o,
  output logic                  valid_o,
  output brsm_pkg::brsm_state_t state_o,
  input  logic                  ready_i
);
  import brsm_pkg::*;

  logic        valid_q, valid_d;
  brsm_state_t state_q, state_d;
  logic        load;

  // Take a new transaction when empty or when the held one leaves
  assign ready_o = ~valid_q | ready_i;
  assign load    = valid_i & ready_o;
  assign valid_d = load ? 1'b1 : (valid_q & ~ready_i);
  assign state_d = load ? brsm_step(state_i) : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

// ===== src/booth_radix2_signed_multiplier_core.sv =====
// Radix-2 Booth signed multiplier core: Width-stage pipeline, one Booth step per stage.
// Each stage registers its step and holds one add/subtract of Width+1 bits.
// Throughput: one transaction per cycle while the output side is ready.
// A stalled output holds the last stage; earlier stages keep filling any bubbles.
// Reset (rst_ni low, asynchronous) clears every stage valid bit; payload is not reset.
// Depends on brsm_pkg, brsm_in_if, brsm_out_if and brsm_stage.
module booth_radix2_signed_multiplier_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  brsm_in_if.sink    in_i,
  brsm_out_if.source out_o
);
  import brsm_pkg::*;

  // Index 0 is the input side, index Width the output of the last stage
  logic        [Width:0] vld;
  logic        [Width:0] rdy;
  brsm_state_t           st [Width+1];
  brsm_state_t           last_st;

  // Seed the pipeline: A cleared, Q-1 cleared, M sign-extended by one bit
  always_comb begin
    st[0].acc    = '0;
    st[0].q      = in_i.multiplier;
    st[0].q_prev = 1'b0;
    st[0].m      = {in_i.multiplicand[Width-1], in_i.multiplicand};
  end

  assign vld[0]     = in_i.valid;
  assign in_i.ready = rdy[0];

  // One stage per Booth step; the ready chain lets bubbles collapse
  for (genvar k = 0; k < Width; k++) begin : g_stage
    brsm_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k]),
      .state_i (st[k]),
      .ready_o (rdy[k]),
      .valid_o (vld[k+1]),
      .state_o (st[k+1]),
      .ready_i (rdy[k+1])
    );
  end

  assign last_st       = st[Width];
  assign rdy[Width]    = out_o.ready;
  assign out_o.valid   = vld[Width];
  // Product is the low Width bits of A followed by Q
  assign out_o.product = {last_st.acc[Width-1:0], last_st.q};

  // Assertions

  logic in_acc, out_acc;
  assign in_acc  = in_i.valid & in_i.ready;
  assign out_acc = out_o.valid & out_o.ready;

  // An unstalled output never backpressures the operand side
  a_no_spurious_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.ready |-> in_i.ready)
    else $error("input stalled while output side is ready");

  // Occupancy tracks accepted minus delivered transactions: nothing lost or duplicated
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rst_ni |=> ($countones(vld[Width:1]) ==
                $past($countones(vld[Width:1])) + $past(in_acc) - $past(out_acc)))
    else $error("pipeline occupancy out of step with handshakes");

  // The guard bit of A must agree with the product sign: the result is exact
  a_exact_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (last_st.acc[AccWidth-1] == last_st.acc[Width-1]))
    else $error("accumulator overflowed the product width");

endmodule

// ===== verif/booth_radix2_signed_multiplier_core_tb.sv =====
// Self-checking testbench for the radix-2 Booth signed multiplier core.
// Needs brsm_pkg, brsm_in_if, brsm_out_if and the core; reads no files.
module booth_radix2_signed_multiplier_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brsm_pkg::*;

  // Give up once no transaction has moved on either channel for this many cycles
  localparam int unsigned StallLimit  = 2000;
  // Cycles the receiver holds off during the back-pressure burst
  localparam int unsigned HoldOffLen  = 60;
  localparam int unsigned BurstItems  = 40;
  localparam int unsigned PhaseItems  = 150;
  localparam int unsigned NumDirected = 24;

  // One row of directed stimulus; when fixed is set, want is the product read off by hand
  typedef struct packed {
    operand_t m;
    operand_t q;
    logic     fixed;
    product_t want;
  } booth_row_t;

  // One product still owed by the core, with its operands for the report
  typedef struct packed {
    operand_t m;
    operand_t q;
    product_t want;
  } product_due_t;

  // Extremes, sign combinations and bit patterns that make Booth recoding busy
  localparam booth_row_t DirectedRows [NumDirected] = '{
    '{8'sh00, 8'sh00, 1'b1, 16'sh0000},
    '{8'sh7f, 8'sh7f, 1'b1, 16'sh3f01},
    '{8'sh80, 8'sh80, 1'b1, 16'sh4000},  // most negative squared: needs the wide accumulator
    '{8'sh80, 8'sh7f, 1'b1, 16'shc080},
    '{8'sh7f, 8'sh80, 1'b1, 16'shc080},
    '{8'sh80, 8'sh01, 1'b1, 16'shff80},
    '{8'sh01, 8'sh80, 1'b1, 16'shff80},
    '{8'sh80, 8'shff, 1'b1, 16'sh0080},
    '{8'shff, 8'sh80, 1'b1, 16'sh0080},
    '{8'shff, 8'shff, 1'b1, 16'sh0001},
    '{8'sh01, 8'shff, 1'b1, 16'shffff},
    '{8'sh80, 8'sh00, 1'b1, 16'sh0000},
    '{8'sh00, 8'sh80, 1'b1, 16'sh0000},
    '{8'sh7f, 8'shff, 1'b1, 16'shff81},
    '{8'sh55, 8'shaa, 1'b0, 16'sh0000},
    '{8'shaa, 8'sh55, 1'b0, 16'sh0000},
    '{8'sh33, 8'shcc, 1'b0, 16'sh0000},
    '{8'sh6d, 8'shb2, 1'b0, 16'sh0000},
    '{8'sh80, 8'sh55, 1'b0, 16'sh0000},
    '{8'sh80, 8'shaa, 1'b0, 16'sh0000},
    '{8'sh7f, 8'sh55, 1'b0, 16'sh0000},
    '{8'shc3, 8'sh3c, 1'b0, 16'sh0000},
    '{8'sh01, 8'sh7f, 1'b0, 16'sh0000},
    '{8'shfe, 8'sh81, 1'b0, 16'sh0000}
  };

  logic clk_i;
  logic rst_ni;

  brsm_in_if  in_if ();
  brsm_out_if out_if ();

  booth_radix2_signed_multiplier_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow payload travelling with the operands: a hand-read product for directed rows
  logic     row_fixed;
  product_t row_want;

  product_due_t products_due[$];
  product_due_t due;
  int unsigned  mismatches;
  int unsigned  quiet_cycles;

  // Idling knobs; once set up, the stall rate and hold-off ticket are written by nonblocking assignment
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_ticket;
  int unsigned hold_off_seen;
  int unsigned hold_off_left;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Radix-2 Booth: WIDTH steps over a Width+1 bit accumulator, so even the most
  // negative multiplicand is subtracted without overflow.
  function automatic product_t booth_product(operand_t m, operand_t q);
    logic [AccWidth-1:0] acc;
    logic [AccWidth-1:0] m_wide;
    logic [Width-1:0]    q_sh;
    logic                q_last;
    acc    = '0;
    m_wide = {m[Width-1], m};
    q_sh   = q;
    q_last = 1'b0;
    for (int step = 0; step < Width; step++) begin
      case ({q_sh[0], q_last})
        BoothSub: acc = acc - m_wide;
        BoothAdd: acc = acc + m_wide;
        default:  acc = acc;
      endcase
      q_last = q_sh[0];
      q_sh   = {acc[0], q_sh[Width-1:1]};
      acc    = {acc[AccWidth-1], acc[AccWidth-1:1]};
    end
    return {acc[Width-1:0], q_sh};
  endfunction

  // Bias random operands towards the corners now and then
  function automatic operand_t pick_operand();
    operand_t corners [7];
    corners = '{8'sh80, 8'sh7f, 8'sh00, 8'shff, 8'sh01, 8'sh55, 8'shaa};
    if ($urandom_range(7) == 0) begin
      return corners[$urandom_range(6)];
    end
    return operand_t'($urandom);
  endfunction

  // Offer one operand pair after an optional random gap; return once it is accepted
  task automatic offer_pair(operand_t m, operand_t q, logic fixed, product_t want);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.multiplicand <= m;
    in_if.multiplier   <= q;
    row_fixed          <= fixed;
    row_want           <= want;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Drop valid and hold the sender until every owed product has come back
  task automatic drain_products();
    in_if.valid <= 1'b0;
    while (products_due.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever the sender asks for one
  initial begin
    out_if.ready  = 1'b0;
    hold_off_seen = 0;
    hold_off_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_ticket != hold_off_seen) begin
        hold_off_seen = hold_off_ticket;
        hold_off_left = HoldOffLen;
      end
      if (hold_off_left != 0) begin
        hold_off_left--;
        out_if.ready <= 1'b0;
      end else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Scoreboard and watchdog: sample both channels on the edge, before any update lands
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        products_due.push_back('{in_if.multiplicand, in_if.multiplier,
            row_fixed ? row_want : booth_product(in_if.multiplicand, in_if.multiplier)});
      end
      if (out_if.valid && out_if.ready) begin
        if (products_due.size() == 0) begin
          $display("%0t: product %0d arrived with none expected", $time, out_if.product);
          mismatches++;
        end else begin
          due = products_due.pop_front();
          if (out_if.product !== due.want) begin
            $display("%0t: %0d * %0d: expected product %0d, got %0d",
                     $time, due.m, due.q, due.want, out_if.product);
            mismatches++;
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
          $display("** booth_radix2_signed_multiplier_core: FAILED **");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned idle_plan [4][2];
    // sender idle %, receiver stall %: none, sender only, receiver only, both
    idle_plan = '{'{0, 0}, '{53, 0}, '{0, 53}, '{36, 36}};

    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.multiplicand = '0;
    in_if.multiplier   = '0;
    row_fixed          = 1'b0;
    row_want           = '0;
    mismatches         = 0;
    quiet_cycles       = 0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_off_ticket    = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at full rate on both sides
    foreach (DirectedRows[i]) begin
      offer_pair(DirectedRows[i].m, DirectedRows[i].q, DirectedRows[i].fixed,
                 DirectedRows[i].want);
    end

    // Back-pressure burst: hold the receiver off while the sender keeps offering,
    // so the pipeline fills up and stalls the operand channel
    hold_off_ticket <= hold_off_ticket + 1;
    for (int n = 0; n < BurstItems; n++) begin
      offer_pair(pick_operand(), pick_operand(), 1'b0, '0);
    end
    drain_products();

    // Random operand pairs under each idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_plan[ph][0];
      recv_stall_pct <= idle_plan[ph][1];
      for (int n = 0; n < PhaseItems; n++) begin
        offer_pair(pick_operand(), pick_operand(), 1'b0, '0);
      end
    end

    drain_products();
    // Allow for a stray product trailing behind the last expected one
    repeat (2 * Width + 4) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("** booth_radix2_signed_multiplier_core: PASSED **");
    end else begin
      $display("** booth_radix2_signed_multiplier_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== booth_radix2_signed_multiplier_core.f =====
src/brsm_pkg.sv
src/brsm_in_if.sv
src/brsm_out_if.sv
src/brsm_stage.sv
src/booth_radix2_signed_multiplier_core.sv
verif/booth_radix2_signed_multiplier_core_tb.sv
